[hw/rtl/a85_pkg.sv]
// Shared types and constants for the Ascii85 stream encoder.
package a85_pkg;

  localparam logic ACT_DATA   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [6:0] CH_BANG  = 7'd33;
  localparam logic [6:0] CH_Z     = 7'd122;
  localparam logic [6:0] CH_TILDE = 7'd126;
  localparam logic [6:0] CH_GT    = 7'd62;
  localparam logic [6:0] CH_NL    = 7'd10;

  localparam logic [6:0] ZERO_LINE_LIMIT  = 7'd76;
  localparam logic [6:0] GROUP_LINE_LIMIT = 7'd80;

  localparam logic [6:0]  RADIX       = 7'd85;
  // floor(x / 85) == (x * DIV85_MAGIC) >> DIV85_SHIFT, exact for any 32-bit x
  localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
  localparam int          DIV85_SHIFT = 38;

  localparam logic [2:0] NUM_DIGITS = 3'd5;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FULL,
    KIND_FIN
  } job_kind_t;

  // closed group or finish request, from collector to converter
  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  n;
    logic        nl;
    logic [31:0] word;
  } job_t;

  // converted group, from converter to emitter
  typedef struct packed {
    job_kind_t       kind;
    logic [1:0]      n;
    logic            nl;
    logic [4:0][6:0] dig;
  } grp_chars_t;

endpackage

[hw/rtl/ascii85_stream_encoder.sv]
// Ascii85 stream encoder top level: collector, converter and emitter.
// Up to one input beat per cycle; a closed group waiting for the converter stalls input.
// A 'z' group and an empty finish skip the divide steps; a digit group passes through
// five steps of the divide-by-85 unit before the emitter shows its first char.
// Up to one result char per cycle while out_ready is high and a converted group is at hand.
// Reset (rst_n low, synchronous) clears group, line count and all valid flags.
module ascii85_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last
);

  logic                job_valid;
  logic                job_ready;
  a85_pkg::job_t       job;
  logic                grp_valid;
  logic                grp_ready;
  a85_pkg::grp_chars_t grp;

  a85_group u_group (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job)
  );

  a85_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  a85_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

[hw/rtl/a85_group.sv]
// Byte collector: builds 32-bit groups, tracks line length, issues jobs.
module a85_group (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [7:0]    in_data_byte,
  output logic          job_valid,
  input  logic          job_ready,
  output a85_pkg::job_t job
);

  logic [31:0]   grp_word_r, grp_word_nxt;
  logic [1:0]    grp_cnt_r, grp_cnt_nxt;
  logic [6:0]    line_r, line_nxt;
  logic          job_v_r, job_v_nxt;
  a85_pkg::job_t job_r, job_nxt;

  logic        accept;
  logic [31:0] word_sh;
  logic [31:0] word_pad;
  logic [6:0]  line_p1;
  logic [6:0]  line_p5;

  assign in_ready  = !job_v_r || job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = job_v_r;
  assign job       = job_r;

  assign word_sh = {grp_word_r[23:0], in_data_byte};
  assign line_p1 = line_r + 7'd1;
  assign line_p5 = line_r + 7'd5;

  always_comb begin
    case (grp_cnt_r)
      2'd1:    word_pad = {grp_word_r[7:0], 24'd0};
      2'd2:    word_pad = {grp_word_r[15:0], 16'd0};
      2'd3:    word_pad = {grp_word_r[23:0], 8'd0};
      default: word_pad = 32'd0;
    endcase
  end

  always_comb begin
    grp_word_nxt = grp_word_r;
    grp_cnt_nxt  = grp_cnt_r;
    line_nxt     = line_r;
    job_nxt      = job_r;
    job_v_nxt    = job_v_r && !job_ready;
    if (accept) begin
      if (in_action == a85_pkg::ACT_FINISH) begin
        job_nxt.kind = a85_pkg::KIND_FIN;
        job_nxt.n    = grp_cnt_r;
        job_nxt.nl   = 1'b0;
        job_nxt.word = word_pad;
        job_v_nxt    = 1'b1;
        grp_word_nxt = 32'd0;
        grp_cnt_nxt  = 2'd0;
        line_nxt     = 7'd0;
      end else if (grp_cnt_r == 2'd3) begin
        grp_cnt_nxt  = 2'd0;
        grp_word_nxt = 32'd0;
        job_nxt.n    = 2'd0;
        job_nxt.word = word_sh;
        job_v_nxt    = 1'b1;
        if (word_sh == 32'd0) begin
          job_nxt.kind = a85_pkg::KIND_ZERO;
          job_nxt.nl   = (line_p1 >= a85_pkg::ZERO_LINE_LIMIT);
          line_nxt     = job_nxt.nl ? 7'd0 : line_p1;
        end else begin
          job_nxt.kind = a85_pkg::KIND_FULL;
          job_nxt.nl   = (line_p5 >= a85_pkg::GROUP_LINE_LIMIT);
          line_nxt     = job_nxt.nl ? 7'd0 : line_p5;
        end
      end else begin
        grp_word_nxt = word_sh;
        grp_cnt_nxt  = grp_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_word_r <= 32'd0;
      grp_cnt_r  <= 2'd0;
      line_r     <= 7'd0;
      job_v_r    <= 1'b0;
    end else begin
      grp_word_r <= grp_word_nxt;
      grp_cnt_r  <= grp_cnt_nxt;
      line_r     <= line_nxt;
      job_v_r    <= job_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

[hw/rtl/a85_conv.sv]
// Base-85 converter: one digit per cycle, least significant first.
module a85_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  a85_pkg::job_t       job,
  output logic                grp_valid,
  input  logic                grp_ready,
  output a85_pkg::grp_chars_t grp
);

  logic                cv_v_r, cv_v_nxt;
  logic [2:0]          cv_cnt_r, cv_cnt_nxt;
  logic [31:0]         cv_word_r, cv_word_nxt;
  a85_pkg::grp_chars_t cv_r, cv_nxt;

  logic        load;
  logic        need_conv;
  logic [63:0] prod;
  logic [25:0] quo;
  logic [6:0]  quo_x85;
  logic [6:0]  digit;

  assign grp_valid = cv_v_r && (cv_cnt_r == 3'd0);
  assign job_ready = !cv_v_r || (grp_valid && grp_ready);
  assign load      = job_valid && job_ready;
  assign grp       = cv_r;

  assign need_conv = (job.kind == a85_pkg::KIND_FULL) ||
                     ((job.kind == a85_pkg::KIND_FIN) && (job.n != 2'd0));

  // reciprocal divide; only the low 7 bits matter for the remainder
  assign prod    = {32'd0, cv_word_r} * {32'd0, a85_pkg::DIV85_MAGIC};
  assign quo     = prod[63:a85_pkg::DIV85_SHIFT];
  assign quo_x85 = quo[6:0] * a85_pkg::RADIX;
  assign digit   = cv_word_r[6:0] - quo_x85;

  always_comb begin
    cv_v_nxt    = cv_v_r;
    cv_cnt_nxt  = cv_cnt_r;
    cv_word_nxt = cv_word_r;
    cv_nxt      = cv_r;
    if (load) begin
      cv_v_nxt    = 1'b1;
      cv_cnt_nxt  = need_conv ? a85_pkg::NUM_DIGITS : 3'd0;
      cv_word_nxt = job.word;
      cv_nxt.kind = job.kind;
      cv_nxt.n    = job.n;
      cv_nxt.nl   = job.nl;
    end else if (grp_valid && grp_ready) begin
      cv_v_nxt = 1'b0;
    end else if (cv_v_r && (cv_cnt_r != 3'd0)) begin
      cv_nxt.dig[cv_cnt_r - 3'd1] = digit;
      cv_word_nxt = {6'd0, quo};
      cv_cnt_nxt  = cv_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_v_r   <= 1'b0;
      cv_cnt_r <= 3'd0;
    end else begin
      cv_v_r   <= cv_v_nxt;
      cv_cnt_r <= cv_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cv_word_r <= cv_word_nxt;
    cv_r      <= cv_nxt;
  end

endmodule

[hw/rtl/a85_emit.sv]
// Character emitter: walks a converted group and drives the result channel.
module a85_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  a85_pkg::grp_chars_t grp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_char,
  output logic                out_last
);

  logic                em_v_r, em_v_nxt;
  logic [2:0]          em_idx_r, em_idx_nxt;
  a85_pkg::grp_chars_t em_r, em_nxt;

  logic       beat;
  logic [2:0] nd;
  logic [2:0] n_chars;
  logic [6:0] dig_char;

  assign out_valid = em_v_r;
  assign beat      = out_valid && out_ready;
  assign grp_ready = !em_v_r || (beat && out_last);

  // digits shown on a finish: none for an empty group, else n+1
  assign nd = (em_r.n == 2'd0) ? 3'd0 : ({1'b0, em_r.n} + 3'd1);

  always_comb begin
    dig_char = a85_pkg::CH_BANG;
    if (em_idx_r < a85_pkg::NUM_DIGITS) begin
      dig_char = em_r.dig[em_idx_r] + a85_pkg::CH_BANG;
    end
  end

  always_comb begin
    out_char = a85_pkg::CH_NL;
    n_chars  = 3'd1;
    case (em_r.kind)
      a85_pkg::KIND_ZERO: begin
        n_chars  = em_r.nl ? 3'd2 : 3'd1;
        out_char = (em_idx_r == 3'd0) ? a85_pkg::CH_Z : a85_pkg::CH_NL;
      end
      a85_pkg::KIND_FULL: begin
        n_chars  = em_r.nl ? 3'd6 : 3'd5;
        out_char = (em_idx_r < a85_pkg::NUM_DIGITS) ? dig_char : a85_pkg::CH_NL;
      end
      a85_pkg::KIND_FIN: begin
        n_chars = nd + 3'd3;
        if (em_idx_r < nd) begin
          out_char = dig_char;
        end else if (em_idx_r == nd) begin
          out_char = a85_pkg::CH_TILDE;
        end else if (em_idx_r == nd + 3'd1) begin
          out_char = a85_pkg::CH_GT;
        end else begin
          out_char = a85_pkg::CH_NL;
        end
      end
      default: begin
        n_chars  = 3'd1;
        out_char = a85_pkg::CH_NL;
      end
    endcase
  end

  assign out_last = (em_idx_r == n_chars - 3'd1);

  always_comb begin
    em_v_nxt   = em_v_r;
    em_idx_nxt = em_idx_r;
    em_nxt     = em_r;
    if (grp_valid && grp_ready) begin
      em_v_nxt   = 1'b1;
      em_idx_nxt = 3'd0;
      em_nxt     = grp;
    end else if (beat) begin
      if (out_last) begin
        em_v_nxt = 1'b0;
      end else begin
        em_idx_nxt = em_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r   <= 1'b0;
      em_idx_r <= 3'd0;
    end else begin
      em_v_r   <= em_v_nxt;
      em_idx_r <= em_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_r <= em_nxt;
  end

endmodule

[hw/rtl/a85_checker.sv]
// Port-level checks for the Ascii85 stream encoder, bound to the top level.
module a85_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // newline always ends the chars of one input
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == a85_pkg::CH_NL) |-> out_last)
    else $error("newline not marked last");

  a_tilde_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == a85_pkg::CH_TILDE) |-> !out_last)
    else $error("trailer cut short");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= a85_pkg::CH_BANG) || (out_char == a85_pkg::CH_NL))
    else $error("char outside encoded alphabet");

endmodule

bind ascii85_stream_encoder a85_checker u_a85_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .out_last  (out_last)
);

[tb/sv/tb.sv]
// Self-checking testbench for the Ascii85 stream encoder: queue-fed driver, monitor, predictor.
module tb;

  localparam int RANDOM_ITEMS   = 425;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int MID_PAUSE_AT   = 300;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic       pause_mark;  // sender waits here until every expected char is out
    logic       action;
    logic [7:0] data;
  } enc_item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_beat_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = a85_pkg::ACT_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_last;

  enc_item_t  pending_items[$];
  char_beat_t exp_chars[$];

  // encoder state as predicted
  logic [31:0] grp_word = '0;
  int unsigned grp_cnt = 0;
  logic [6:0]  line_cnt = '0;

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int finishes = 0;
  int zero_groups = 0;
  int line_breaks = 0;

  ascii85_stream_encoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // five base-85 digits, most significant first at index 0, already offset to ASCII
  function automatic logic [4:0][6:0] base85_digits(logic [31:0] v);
    logic [4:0][6:0] d;
    logic [31:0]     rem;
    rem = v;
    for (int i = 4; i >= 0; i--) begin
      d[i] = 7'(rem % a85_pkg::RADIX) + a85_pkg::CH_BANG;
      rem = rem / a85_pkg::RADIX;
    end
    return d;
  endfunction

  function automatic void encode_beat(logic act, logic [7:0] data);
    logic [6:0]      chars[$];
    logic [4:0][6:0] d;
    logic [31:0]     padded;
    char_beat_t      cb;
    if (act == a85_pkg::ACT_DATA) begin
      grp_word = {grp_word[23:0], data};
      grp_cnt++;
      if (grp_cnt == 4) begin
        grp_cnt = 0;
        if (grp_word == 32'd0) begin
          zero_groups++;
          chars.push_back(a85_pkg::CH_Z);
          line_cnt = line_cnt + 7'd1;
          if (line_cnt >= a85_pkg::ZERO_LINE_LIMIT) begin
            chars.push_back(a85_pkg::CH_NL);
            line_cnt = '0;
            line_breaks++;
          end
        end else begin
          d = base85_digits(grp_word);
          for (int i = 0; i < 5; i++) chars.push_back(d[i]);
          grp_word = '0;
          line_cnt = line_cnt + 7'd5;
          if (line_cnt >= a85_pkg::GROUP_LINE_LIMIT) begin
            chars.push_back(a85_pkg::CH_NL);
            line_cnt = '0;
            line_breaks++;
          end
        end
      end
    end else begin
      finishes++;
      // partial group: zero-padded, n+1 digits, never 'z', no line check
      if (grp_cnt != 0) begin
        padded = grp_word << (8 * (4 - grp_cnt));
        d = base85_digits(padded);
        for (int i = 0; i <= int'(grp_cnt); i++) chars.push_back(d[i]);
      end
      chars.push_back(a85_pkg::CH_TILDE);
      chars.push_back(a85_pkg::CH_GT);
      chars.push_back(a85_pkg::CH_NL);
      grp_word = '0;
      grp_cnt = 0;
      line_cnt = '0;
    end
    foreach (chars[i]) begin
      cb.ch = chars[i];
      cb.last = (i == chars.size() - 1);
      exp_chars.push_back(cb);
    end
  endfunction

  function automatic void add_item(logic act, logic [7:0] data);
    enc_item_t it;
    it.pause_mark = 1'b0;
    it.action = act;
    it.data = data;
    pending_items.push_back(it);
  endfunction

  function automatic void add_pause();
    enc_item_t it;
    it = '0;
    it.pause_mark = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------- driver ----------------
  int        burst_left;
  int        gap_left;
  enc_item_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 12);
    end else begin
      if (in_valid && in_ready) begin
        encode_beat(in_action, in_data_byte);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && pending_items[0].pause_mark &&
            exp_chars.size() == 0)
          void'(pending_items.pop_front());
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !pending_items[0].pause_mark) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_action <= nxt.action;
          in_data_byte <= nxt.data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  int       rx_left;
  int       hold_cnt;
  bit       hold_done = 1'b0;
  rx_mode_t rx_mode;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left = 0;
      hold_cnt = 0;
      rx_mode = RX_OPEN;
    end else begin
      // one long back-pressure stretch, input side must fill and stall
      if (!hold_done && beats_out >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        if (rx_left <= 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= (rx_left % 4 == 0);
          default:   out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------- monitor ----------------
  char_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (exp_chars.size() == 0) begin
        $error("unexpected output beat: out_char=%0d out_last=%0d", out_char, out_last);
        errors++;
      end else begin
        want = exp_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char mismatch: expected %0d, actual %0d", want.ch, out_char);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %0d, actual %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus and end of run ----------------
  int rand_items;
  int n_groups;
  int n_tail;
  int pick;
  bit mid_pause_done;

  initial begin
    // directed: zero group, max group, empty finish with junk byte, partial groups
    repeat (4) add_item(a85_pkg::ACT_DATA, 8'h00);
    repeat (4) add_item(a85_pkg::ACT_DATA, 8'hFF);
    add_item(a85_pkg::ACT_FINISH, 8'hA5);
    add_item(a85_pkg::ACT_DATA, 8'h80);
    add_item(a85_pkg::ACT_FINISH, 8'h00);
    add_item(a85_pkg::ACT_DATA, 8'h12);
    add_item(a85_pkg::ACT_DATA, 8'h34);
    add_item(a85_pkg::ACT_FINISH, 8'h5A);
    repeat (3) add_item(a85_pkg::ACT_DATA, 8'h00);   // zero partial group, no 'z'
    add_item(a85_pkg::ACT_FINISH, 8'hFF);
    add_item(a85_pkg::ACT_FINISH, 8'h00);
    add_item(a85_pkg::ACT_DATA, 8'h01);
    repeat (3) add_item(a85_pkg::ACT_DATA, 8'h00);
    add_pause();

    // random: long streams of groups so lines wrap, then zero to three tail bytes and a finish
    rand_items = 0;
    mid_pause_done = 1'b0;
    while (rand_items < RANDOM_ITEMS) begin
      n_groups = $urandom_range(3, 40);
      for (int g = 0; g < n_groups && rand_items < RANDOM_ITEMS; g++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          repeat (4) add_item(a85_pkg::ACT_DATA, 8'h00);
          rand_items += 4;
        end else if (pick < 95) begin
          repeat (4) add_item(a85_pkg::ACT_DATA, rand_byte());
          rand_items += 4;
        end else begin
          add_item(a85_pkg::ACT_DATA, rand_byte());   // stray byte shifts group alignment
          rand_items++;
        end
      end
      n_tail = $urandom_range(0, 3);
      repeat (n_tail) add_item(a85_pkg::ACT_DATA, rand_byte());
      add_item(a85_pkg::ACT_FINISH, 8'($urandom));
      rand_items += n_tail + 1;
      if (!mid_pause_done && rand_items >= MID_PAUSE_AT) begin
        add_pause();
        mid_pause_done = 1'b1;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || exp_chars.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats (%0d finishes, %0d zero groups), %0d output chars.",
             beats_in, finishes, zero_groups, beats_out);
    $display("Line breaks seen: %0d; one long output stall and two drain pauses applied.",
             line_breaks);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
